FILE: design/page_and_size_class_allocator_core_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the core module, the only one that carries checks.
`ifndef PAGE_AND_SIZE_CLASS_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_AND_SIZE_CLASS_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PASCA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define PASCA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define PASCA_ASSERT(lbl, clk, rst, prop)
`define PASCA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: design/pasca_pkg.sv
// Types, constants and helper functions of the page and size-class allocator.
// Depends on nothing; imported by the core and the class search module.
package pasca_pkg;

   localparam int NumClasses    = 25;
   localparam int ClassRamDepth = 32;
   localparam logic [4:0] LastClass = 5'd24;

   localparam logic [1:0] KIND_ALLOC_PAGE  = 2'd0;
   localparam logic [1:0] KIND_FREE_PAGE   = 2'd1;
   localparam logic [1:0] KIND_ALLOC_BLOCK = 2'd2;
   localparam logic [1:0] KIND_FREE_BLOCK  = 2'd3;

   typedef struct packed {
      logic        start;
      logic [19:0] size;
   } search_req_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [4:0] id;
   } search_rsp_type;

   function automatic logic [12:0] class_bytes(input logic [4:0] id);
      case (id)
         5'd0:    return 13'd8;
         5'd1:    return 13'd16;
         5'd2:    return 13'd24;
         5'd3:    return 13'd32;
         5'd4:    return 13'd40;
         5'd5:    return 13'd48;
         5'd6:    return 13'd56;
         5'd7:    return 13'd64;
         5'd8:    return 13'd80;
         5'd9:    return 13'd96;
         5'd10:   return 13'd112;
         5'd11:   return 13'd128;
         5'd12:   return 13'd160;
         5'd13:   return 13'd192;
         5'd14:   return 13'd224;
         5'd15:   return 13'd256;
         5'd16:   return 13'd288;
         5'd17:   return 13'd336;
         5'd18:   return 13'd368;
         5'd19:   return 13'd408;
         5'd20:   return 13'd448;
         5'd21:   return 13'd512;
         5'd22:   return 13'd1360;
         5'd23:   return 13'd2040;
         default: return 13'd4096;
      endcase
   endfunction

   // A stored class code is folded back into the legal range.
   function automatic logic [4:0] class_mod(input logic [4:0] v);
      return (v >= 5'd25) ? v - 5'd25 : v;
   endfunction

endpackage

FILE: design/page_and_size_class_allocator_core.sv
// Page and size-class allocator: free page stack, page refcounts and block classes 0 to 24.
// Depends on pasca_pkg, pasca_ram, pasca_class_search and the assertion macro header.
//
// Usage: a request (req_kind, req_request_size, req_address) transfers when req_valid
// is high and req_stall low. Every request yields exactly one result transfer on the
// rsp_ channel (rsp_result_address, rsp_status, rsp_pages_left), in request order.
// One request is handled at a time; req_stall is high while it is in progress.
// Page alloc reads the stack top, then that page's refcount, then writes the refcount;
// an empty pool goes straight to the result. Page free reads and writes the refcount.
// Block free reads the page's class, then the class entry, then writes the link and
// class memories; a header address goes straight to the result. Block alloc runs the
// class search over class index 0 to 24 (one compare per cycle), reads the class entry,
// then pops the class list, carves, takes a fresh page, or fails when no page is left.
// req_stall falls with the edge that registers the result, so the next request is
// accepted in the cycle after.
// The result sits in an output register; the next request is taken while it waits,
// but a finished request holds until the receiver has taken the previous result.
// After reset a clearing pass loads the page stack, refcounts and class table;
// req_stall stays high during it.
`include "page_and_size_class_allocator_core_macros.svh"
module page_and_size_class_allocator_core
   import pasca_pkg::*;
#(
   parameter int PAGE_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [19:0] req_request_size,
   input  logic [17:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [17:0] rsp_result_address,
   output logic        rsp_status,
   output logic [6:0]  rsp_pages_left
);

   localparam int PW     = $clog2(PAGE_COUNT);
   localparam int DW     = $clog2(PAGE_COUNT + 1);
   localparam int LW     = $clog2(PAGE_COUNT * 512);
   localparam int ClrLen = (PAGE_COUNT > ClassRamDepth) ? PAGE_COUNT : ClassRamDepth;
   localparam int CW     = $clog2(ClrLen);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_PG_RD, S_PG_RC, S_PG_WR, S_FR_RC, S_FR_WR, S_CS_WAIT,
      S_CL_RD, S_CL_EVAL, S_LK_RD, S_LK_WR, S_CARVE, S_BF_PSC, S_BF_CL, S_BF_WR,
      S_FINISH
   } state_type;

   function automatic logic [PW-1:0] page_of(input logic [17:0] a);
      logic [PW+5:0] t;
      t = {{PW{1'b0}}, a[17:12]};
      return t[PW-1:0];
   endfunction

   function automatic logic [17:0] page_addr(input logic [PW-1:0] p);
      logic [PW+17:0] t;
      t = {{18{1'b0}}, p};
      t = t << 12;
      return t[17:0];
   endfunction

   function automatic logic [LW-1:0] link_idx(input logic [17:0] a);
      logic [LW+14:0] t;
      t = {{LW{1'b0}}, a[17:3]};
      return t[LW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in, clr_next;
   logic [17:0] addr_ff, addr_in;
   logic [4:0]  id_ff, id_in;
   logic [17:0] head_ff, head_in;
   logic [17:0] carve_ff, carve_in;
   logic [17:0] ptr_ff, ptr_in;
   logic [PW-1:0] page_ff, page_in;
   logic        blk_ff, blk_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [DW-1:0] alloc_ff, alloc_in;
   logic [17:0] res_addr_ff, res_addr_in;
   logic        res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [17:0] rsp_addr_ff, rsp_addr_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [6:0]  rsp_left_ff, rsp_left_in;

   logic [DW-1:0] depth_m1;
   logic [DW-1:0] left;
   logic [DW+6:0] left_ext;
   logic        req_page_ok;
   logic [12:0] bytes;
   logic [18:0] carve_end;
   logic        crossed;
   logic [17:0] carve_new;

   logic          stk_we;
   logic [PW-1:0] stk_wa, stk_wd, stk_ra, stk_rd;
   logic          rc_we;
   logic [PW-1:0] rc_wa, rc_ra;
   logic [7:0]    rc_wd, rc_rd;
   logic          psc_we;
   logic [PW-1:0] psc_wa, psc_ra;
   logic [4:0]    psc_wd, psc_rd;
   logic          cls_we;
   logic [4:0]    cls_wa, cls_ra;
   logic [35:0]   cls_wd, cls_rd;
   logic          lnk_we;
   logic [LW-1:0] lnk_wa, lnk_ra;
   logic [17:0]   lnk_wd, lnk_rd;

   search_req_type srch_req;
   search_rsp_type srch_rsp;

   pasca_ram #(.Width(PW), .Depth(PAGE_COUNT)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd));

   pasca_ram #(.Width(8), .Depth(PAGE_COUNT)) u_refcount (
      .clock(clock), .we(rc_we), .waddr(rc_wa), .wdata(rc_wd),
      .raddr(rc_ra), .rdata(rc_rd));

   pasca_ram #(.Width(5), .Depth(PAGE_COUNT)) u_page_class (
      .clock(clock), .we(psc_we), .waddr(psc_wa), .wdata(psc_wd),
      .raddr(psc_ra), .rdata(psc_rd));

   // Each class entry holds the free-list head above the carve pointer.
   pasca_ram #(.Width(36), .Depth(ClassRamDepth)) u_class (
      .clock(clock), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd),
      .raddr(cls_ra), .rdata(cls_rd));

   pasca_ram #(.Width(18), .Depth(PAGE_COUNT * 512)) u_link (
      .clock(clock), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
      .raddr(lnk_ra), .rdata(lnk_rd));

   pasca_class_search u_search (
      .clock(clock), .reset(reset), .req(srch_req), .rsp(srch_rsp));

   assign clr_next    = clr_ff + 1'b1;
   assign depth_m1    = depth_ff - 1'b1;
   assign req_page_ok = 32'(req_address[17:12]) < PAGE_COUNT;
   assign bytes       = class_bytes(id_ff);
   assign carve_end   = {1'b0, ptr_ff} + {5'b0, bytes, 1'b0} - 19'd1;
   assign crossed     = carve_end[18:12] != {1'b0, ptr_ff[17:12]};
   assign carve_new   = crossed ? 18'd0 : ptr_ff + {5'b0, bytes};
   assign left        = (alloc_ff >= DW'(PAGE_COUNT - 1)) ? '0
                        : DW'(PAGE_COUNT - 1) - alloc_ff;
   assign left_ext    = {7'b0, left};

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      carve_in      = carve_ff;
      ptr_in        = ptr_ff;
      page_in       = page_ff;
      blk_in        = blk_ff;
      depth_in      = depth_ff;
      alloc_in      = alloc_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_left_in   = rsp_left_ff;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
      rc_we  = 1'b0; rc_wa  = '0; rc_wd  = '0; rc_ra  = '0;
      psc_we = 1'b0; psc_wa = '0; psc_wd = '0; psc_ra = '0;
      cls_we = 1'b0; cls_wa = '0; cls_wd = '0; cls_ra = '0;
      lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
      srch_req.start = 1'b0;
      srch_req.size  = req_request_size;

      unique case (state_ff)
         S_CLEAR: begin
            stk_we = 32'(clr_ff) < PAGE_COUNT;
            stk_wa = clr_ff[PW-1:0];
            stk_wd = clr_next[PW-1:0];
            rc_we  = 32'(clr_ff) < PAGE_COUNT;
            rc_wa  = clr_ff[PW-1:0];
            rc_wd  = (clr_ff == '0) ? 8'd1 : 8'd0;
            cls_we = 32'(clr_ff) < ClassRamDepth;
            cls_wa = clr_ff[4:0];
            if (clr_ff == CW'(ClrLen - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_next;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               addr_in       = req_address;
               res_addr_in   = 18'd0;
               res_status_in = 1'b0;
               blk_in        = 1'b0;
               unique case (req_kind)
                  KIND_ALLOC_PAGE: begin
                     if (depth_ff == '0) begin
                        res_status_in = 1'b1;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_PG_RD;
                     end
                  end
                  KIND_FREE_PAGE: begin
                     state_in = req_page_ok ? S_FR_RC : S_FINISH;
                  end
                  KIND_ALLOC_BLOCK: begin
                     srch_req.start = 1'b1;
                     state_in       = S_CS_WAIT;
                  end
                  KIND_FREE_BLOCK: begin
                     // Frees that land in the page header are dropped.
                     if (req_page_ok && req_address[11:3] != 9'd0) begin
                        state_in = S_BF_PSC;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_PG_RD: begin
            stk_ra   = depth_m1[PW-1:0];
            state_in = S_PG_RC;
         end
         S_PG_RC: begin
            page_in  = stk_rd;
            rc_ra    = stk_rd;
            state_in = S_PG_WR;
         end
         S_PG_WR: begin
            rc_we    = 1'b1;
            rc_wa    = page_ff;
            rc_wd    = (rc_rd == 8'd255) ? 8'd255 : rc_rd + 8'd1;
            depth_in = depth_ff - 1'b1;
            alloc_in = alloc_ff + 1'b1;
            if (blk_ff) begin
               psc_we   = 1'b1;
               psc_wa   = page_ff;
               psc_wd   = id_ff;
               ptr_in   = page_addr(page_ff) + 18'd8;
               state_in = S_CARVE;
            end else begin
               res_addr_in = page_addr(page_ff);
               state_in    = S_FINISH;
            end
         end
         S_FR_RC: begin
            rc_ra    = page_of(addr_ff);
            state_in = S_FR_WR;
         end
         S_FR_WR: begin
            if (rc_rd != 8'd0) begin
               rc_we = 1'b1;
               rc_wa = page_of(addr_ff);
               rc_wd = rc_rd - 8'd1;
               if (rc_rd == 8'd1) begin
                  if (alloc_ff != '0) begin
                     alloc_in = alloc_ff - 1'b1;
                  end
                  if (depth_ff < DW'(PAGE_COUNT)) begin
                     stk_we   = 1'b1;
                     stk_wa   = depth_ff[PW-1:0];
                     stk_wd   = page_of(addr_ff);
                     depth_in = depth_ff + 1'b1;
                  end
               end
            end
            state_in = S_FINISH;
         end
         S_CS_WAIT: begin
            if (srch_rsp.done) begin
               id_in    = srch_rsp.id;
               state_in = S_CL_RD;
            end
         end
         S_CL_RD: begin
            cls_ra   = id_ff;
            state_in = S_CL_EVAL;
         end
         S_CL_EVAL: begin
            head_in  = cls_rd[35:18];
            carve_in = cls_rd[17:0];
            if (cls_rd[35:18] != 18'd0) begin
               state_in = S_LK_RD;
            end else if (cls_rd[17:0] != 18'd0) begin
               ptr_in   = cls_rd[17:0];
               state_in = S_CARVE;
            end else if (depth_ff == '0) begin
               res_status_in = 1'b1;
               state_in      = S_FINISH;
            end else begin
               blk_in   = 1'b1;
               state_in = S_PG_RD;
            end
         end
         S_LK_RD: begin
            lnk_ra   = link_idx(head_ff);
            state_in = S_LK_WR;
         end
         S_LK_WR: begin
            cls_we      = 1'b1;
            cls_wa      = id_ff;
            cls_wd      = {lnk_rd, carve_ff};
            res_addr_in = head_ff;
            state_in    = S_FINISH;
         end
         S_CARVE: begin
            cls_we      = 1'b1;
            cls_wa      = id_ff;
            cls_wd      = {head_ff, carve_new};
            res_addr_in = ptr_ff;
            state_in    = S_FINISH;
         end
         S_BF_PSC: begin
            psc_ra   = page_of(addr_ff);
            state_in = S_BF_CL;
         end
         S_BF_CL: begin
            id_in    = class_mod(psc_rd);
            cls_ra   = class_mod(psc_rd);
            state_in = S_BF_WR;
         end
         S_BF_WR: begin
            lnk_we   = 1'b1;
            lnk_wa   = link_idx(addr_ff);
            lnk_wd   = cls_rd[35:18];
            cls_we   = 1'b1;
            cls_wa   = id_ff;
            cls_wd   = {addr_ff, cls_rd[17:0]};
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // Hold until the output register is free or being emptied this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_left_in   = left_ext[6:0];
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= DW'(PAGE_COUNT - 1);
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      id_ff         <= id_in;
      head_ff       <= head_in;
      carve_ff      <= carve_in;
      ptr_ff        <= ptr_in;
      page_ff       <= page_in;
      blk_ff        <= blk_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_pages_left     = rsp_left_ff;

   `PASCA_ASSERT(a_depth_bound, clock, reset, depth_ff <= DW'(PAGE_COUNT))
   `PASCA_ASSERT(a_pool_sum, clock, reset, 32'(alloc_ff) + 32'(depth_ff) <= PAGE_COUNT)
   `PASCA_ASSERT(a_oop_zero, clock, reset, rsp_valid_ff && rsp_status_ff |-> rsp_addr_ff == '0)
   `PASCA_ASSERT(a_search_owner, clock, reset, srch_rsp.busy |-> state_ff == S_CS_WAIT)
   `PASCA_ASSERT_ALWAYS(a_class_range, clock, srch_rsp.done |-> srch_rsp.id <= LastClass)

endmodule

FILE: design/pasca_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module pasca_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/pasca_class_search.sv
// Size-class search: one table compare per cycle until the first class that fits.
// Depends on pasca_pkg for the class table and the search handshake types.
module pasca_class_search
   import pasca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  search_req_type req,
   output search_rsp_type rsp
);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type   state_ff;
   logic [19:0] size_ff;
   logic [4:0]  cnt_ff;
   logic [4:0]  id_ff;
   logic        done_ff;
   logic        hit;
   logic        last;

   assign hit  = size_ff <= {7'b0, class_bytes(cnt_ff)};
   assign last = cnt_ff == LastClass;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  size_ff  <= req.size;
                  cnt_ff   <= 5'd0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               // Oversized requests run off the end and take the last class.
               if (hit || last) begin
                  id_ff    <= cnt_ff;
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.busy = state_ff == S_RUN;
   assign rsp.done = done_ff;
   assign rsp.id   = id_ff;

endmodule
